FILE: hdl/tlc_pkg.sv
package tlc_pkg;
	localparam int CACHE_ENTRIES = 8;
	localparam int PAGE_COUNT = 8;
	localparam int WORD_BITS = 32;
	localparam int SLOT_BITS = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int PAGE_BITS = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int CNT_BITS = $clog2(CACHE_ENTRIES + 1);

	localparam logic [1:0] CFG_CAPACITY = 2'd0;
	localparam logic [1:0] CFG_VIRTUAL_BASE = 2'd1;
	localparam logic [1:0] CFG_PHYSICAL_BASE = 2'd2;

	localparam logic [1:0] ST_HIT = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic [0:0] opcode;
		logic [15:0] virtual_address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] physical_address;
		logic [31:0] data_word;
		logic [0:0] evicted;
		logic [7:0] evicted_address;
		logic [15:0] address_hits;
		logic [15:0] address_misses;
		logic [31:0] total_hits;
		logic [31:0] total_misses;
	} rsp_t;

	typedef struct packed {
		logic [1:0] index;
		logic [15:0] data;
	} cfg_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [15:0] hits;
		logic [15:0] misses;
	} page_t;
endpackage

FILE: hdl/tlc_if.sv
interface tlc_req_if;
	logic valid;
	logic ready;
	tlc_pkg::req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tlc_rsp_if;
	logic valid;
	logic ready;
	tlc_pkg::rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tlc_cfg_if;
	logic valid;
	logic ready;
	tlc_pkg::cfg_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

FILE: hdl/tlc_page_ram.sv
module tlc_page_ram (
	input  logic clk,
	input  logic rd_en,
	input  logic [tlc_pkg::PAGE_BITS-1:0] rd_addr,
	output tlc_pkg::page_t rd_data,
	input  logic wr_en,
	input  logic [tlc_pkg::PAGE_BITS-1:0] wr_addr,
	input  tlc_pkg::page_t wr_data,
	input  logic init_en,
	input  logic [tlc_pkg::PAGE_BITS-1:0] init_addr
);
	tlc_pkg::page_t mem [tlc_pkg::PAGE_COUNT];

	always_ff @(posedge clk) begin
		if (init_en) begin
			mem[init_addr] <= '{word: tlc_pkg::WORD_BITS'(init_addr), hits: '0, misses: '0};
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

FILE: hdl/tlc_entry_ram.sv
module tlc_entry_ram (
	input  logic clk,
	input  logic rd_en,
	input  logic [tlc_pkg::SLOT_BITS-1:0] rd_addr,
	output logic [tlc_pkg::WORD_BITS-1:0] rd_data,
	input  logic wr_en,
	input  logic [tlc_pkg::SLOT_BITS-1:0] wr_addr,
	input  logic [tlc_pkg::WORD_BITS-1:0] wr_data
);
	logic [tlc_pkg::WORD_BITS-1:0] mem [tlc_pkg::CACHE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

FILE: hdl/translated_lru_cache_core.sv
// Translated LRU cache. Requests are taken one at a time: a request that
// faults returns its result in the cycle after it is accepted; a request
// that maps goes through lookup, memory read and write-back, paced by the
// registered reads of the page memory (backing word and per-page counters)
// and the cache word memory. After reset a clearing pass over all PAGE_COUNT
// pages loads the page memory; no request is taken until it is done, while
// configuration writes are taken throughout. Tags, valid bits and recency
// ranks are in registers and are compared over all entries in parallel. A
// result waits in an output register until it is taken.
module translated_lru_cache_core (
	input logic clk,
	input logic arst_n,
	tlc_req_if.sink req,
	tlc_rsp_if.source rsp,
	tlc_cfg_if.sink cfg
);
	localparam int N = tlc_pkg::CACHE_ENTRIES;
	localparam int SB = tlc_pkg::SLOT_BITS;
	localparam int PB = tlc_pkg::PAGE_BITS;
	localparam int CNT_W = tlc_pkg::CNT_BITS;

	typedef enum logic [3:0] {
		S_INIT = 4'b0001,
		S_IDLE = 4'b0010,
		S_READ = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [PB-1:0] init_q;
	logic [3:0] capacity_q;
	logic [15:0] vbase_q;
	logic [7:0] pbase_q;
	logic [7:0] tag_q [N];
	logic [N-1:0] valid_q;
	logic [SB-1:0] rank_q [N];
	logic [31:0] hits_total_q, misses_total_q;
	logic out_valid_q;
	tlc_pkg::rsp_t out_q;

	tlc_pkg::req_t req_s1;
	logic [PB-1:0] off_s1;
	logic [7:0] phys_s1;
	logic hit_s1, ev_s1;
	logic [SB-1:0] slot_s1;
	logic [7:0] ev_addr_s1;

	logic [16:0] diff;
	logic fault;
	logic [PB-1:0] off;
	logic [7:0] phys;
	logic hit;
	logic [SB-1:0] hit_slot, victim, free_slot, slot;
	logic [CNT_W-1:0] count;
	logic [CNT_W-1:0] cap_eff;
	logic do_evict;
	logic [N-1:0] valid_after;
	logic [SB-1:0] best;
	logic found;

	tlc_pkg::page_t page_rd, page_wr;
	logic [tlc_pkg::WORD_BITS-1:0] entry_rd, new_word;
	logic accept;

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign accept = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	assign diff = {1'b0, req.payload.virtual_address} - {1'b0, vbase_q};
	assign fault = diff[16] || (diff[15:0] >= 16'(tlc_pkg::PAGE_COUNT));
	assign off = diff[PB-1:0];
	assign phys = pbase_q + 8'(diff[15:0]);

	always_comb begin
		hit = 1'b0;
		hit_slot = '0;
		count = '0;
		found = 1'b0;
		best = '0;
		victim = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == phys) begin
				hit = 1'b1;
				hit_slot = SB'(i);
			end
		end
		for (int i = 0; i < N; i++) begin
			count = count + CNT_W'(valid_q[i]);
			if (valid_q[i] && (!found || rank_q[i] > best)) begin
				found = 1'b1;
				best = rank_q[i];
				victim = SB'(i);
			end
		end
		if (capacity_q == 4'd0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(capacity_q) > N) begin
			cap_eff = CNT_W'(N);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
		do_evict = !hit && (count >= cap_eff) && found;
		valid_after = valid_q;
		if (do_evict) begin
			valid_after[victim] = 1'b0;
		end
		free_slot = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_after[i]) begin
				free_slot = SB'(i);
			end
		end
		slot = hit ? hit_slot : free_slot;
	end

	tlc_page_ram u_page (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(off),
		.rd_data(page_rd),
		.wr_en(state_q == S_READ),
		.wr_addr(off_s1),
		.wr_data(page_wr),
		.init_en(state_q == S_INIT),
		.init_addr(init_q)
	);

	tlc_entry_ram u_entry (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(slot),
		.rd_data(entry_rd),
		.wr_en(state_q == S_READ),
		.wr_addr(slot_s1),
		.wr_data(new_word)
	);

	always_comb begin
		page_wr = page_rd;
		if (hit_s1) begin
			if (page_rd.hits != 16'hFFFF) page_wr.hits = page_rd.hits + 16'd1;
			new_word = (req_s1.opcode == tlc_pkg::OP_WRITE) ? req_s1.write_data : entry_rd;
		end else begin
			if (page_rd.misses != 16'hFFFF) page_wr.misses = page_rd.misses + 16'd1;
			if (req_s1.opcode == tlc_pkg::OP_WRITE) page_wr.word = req_s1.write_data;
			new_word = page_wr.word;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req.payload;
			off_s1 <= off;
			phys_s1 <= phys;
			hit_s1 <= hit;
			slot_s1 <= slot;
			ev_s1 <= do_evict;
			ev_addr_s1 <= do_evict ? tag_q[victim] : 8'd0;
		end
		if (accept && !fault) begin
			tag_q[slot] <= phys;
		end
		if (accept && fault) begin
			out_q <= '{status: tlc_pkg::ST_FAULT, physical_address: '0, data_word: '0,
				evicted: '0, evicted_address: '0, address_hits: '0, address_misses: '0,
				total_hits: hits_total_q, total_misses: misses_total_q};
		end else if (state_q == S_READ) begin
			out_q <= '{status: hit_s1 ? tlc_pkg::ST_HIT : tlc_pkg::ST_MISS,
				physical_address: phys_s1, data_word: 32'(new_word), evicted: ev_s1,
				evicted_address: ev_addr_s1, address_hits: page_wr.hits,
				address_misses: page_wr.misses,
				total_hits: hits_total_q, total_misses: misses_total_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			capacity_q <= 4'd4;
			vbase_q <= 16'd100;
			pbase_q <= 8'd10;
			valid_q <= '0;
			for (int i = 0; i < N; i++) rank_q[i] <= '0;
			hits_total_q <= '0;
			misses_total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.payload.index)
					tlc_pkg::CFG_CAPACITY: capacity_q <= cfg.payload.data[3:0];
					tlc_pkg::CFG_VIRTUAL_BASE: vbase_q <= cfg.payload.data;
					tlc_pkg::CFG_PHYSICAL_BASE: pbase_q <= cfg.payload.data[7:0];
					default: ;
				endcase
			end
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + PB'(1);
					if (32'(init_q) == tlc_pkg::PAGE_COUNT - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept && fault) begin
						out_valid_q <= 1'b1;
					end else if (accept) begin
						state_q <= S_READ;
						for (int i = 0; i < N; i++) begin
							if (SB'(i) == slot) begin
								rank_q[i] <= '0;
							end else if (hit) begin
								if (valid_q[i] && rank_q[i] < rank_q[slot]) rank_q[i] <= rank_q[i] + SB'(1);
							end else if (valid_after[i]) begin
								rank_q[i] <= rank_q[i] + SB'(1);
							end
						end
						valid_q <= valid_after | (N'(1) << slot);
						if (hit) begin
							if (hits_total_q != 32'hFFFF_FFFF) hits_total_q <= hits_total_q + 32'd1;
						end else begin
							if (misses_total_q != 32'hFFFF_FFFF) misses_total_q <= misses_total_q + 32'd1;
						end
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sim/tb_translated_lru_cache_core.sv
`timescale 1ns / 100ps

module tb_translated_lru_cache_core;
	import tlc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tlc_req_if req_if();
	tlc_rsp_if rsp_if();
	tlc_cfg_if cfg_if();

	translated_lru_cache_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source),
		.cfg(cfg_if.sink)
	);

	always #5 clk = ~clk;

	// cache model state
	logic [3:0] m_capacity;
	logic [15:0] m_vbase;
	logic [7:0] m_pbase;
	logic [7:0] m_tag [CACHE_ENTRIES];
	logic m_valid [CACHE_ENTRIES];
	logic [31:0] m_word [CACHE_ENTRIES];
	int unsigned m_rank [CACHE_ENTRIES];
	logic [31:0] m_backing [PAGE_COUNT];
	logic [15:0] m_hitc [PAGE_COUNT];
	logic [15:0] m_missc [PAGE_COUNT];
	logic [31:0] m_hits_total;
	logic [31:0] m_misses_total;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_sender = 1'b0;
	longint cycles = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic rsp_t predict_access(input req_t rq);
		rsp_t r;
		int unsigned off, slot, cap, count, victim, best, rk;
		bit hit, found;
		logic [7:0] phys;
		r = '0;
		hit = 0;
		slot = 0;
		if (rq.virtual_address < m_vbase || (rq.virtual_address - m_vbase) >= PAGE_COUNT) begin
			r.status = ST_FAULT;
			r.total_hits = m_hits_total;
			r.total_misses = m_misses_total;
			return r;
		end
		off = rq.virtual_address - m_vbase;
		phys = m_pbase + off[7:0];
		for (int i = 0; i < CACHE_ENTRIES; i++)
			if (!hit && m_valid[i] && m_tag[i] == phys) begin
				hit = 1;
				slot = i;
			end
		if (hit) begin
			if (m_hits_total != 32'hFFFFFFFF) m_hits_total++;
			if (m_hitc[off] != 16'hFFFF) m_hitc[off]++;
			rk = m_rank[slot];
			for (int i = 0; i < CACHE_ENTRIES; i++)
				if (m_valid[i] && m_rank[i] < rk) m_rank[i]++;
			m_rank[slot] = 0;
			if (rq.opcode == OP_WRITE) m_word[slot] = rq.write_data;
			r.status = ST_HIT;
		end else begin
			if (m_misses_total != 32'hFFFFFFFF) m_misses_total++;
			if (m_missc[off] != 16'hFFFF) m_missc[off]++;
			count = 0;
			for (int i = 0; i < CACHE_ENTRIES; i++) if (m_valid[i]) count++;
			cap = m_capacity;
			if (cap < 1) cap = 1;
			if (cap > CACHE_ENTRIES) cap = CACHE_ENTRIES;
			if (count >= cap) begin
				found = 0;
				victim = 0;
				best = 0;
				for (int i = 0; i < CACHE_ENTRIES; i++)
					if (m_valid[i] && (!found || m_rank[i] > best)) begin
						found = 1;
						best = m_rank[i];
						victim = i;
					end
				if (found) begin
					m_valid[victim] = 0;
					r.evicted = 1;
					r.evicted_address = m_tag[victim];
				end
			end
			found = 0;
			for (int i = 0; i < CACHE_ENTRIES; i++)
				if (!found && !m_valid[i]) begin
					found = 1;
					slot = i;
				end
			if (rq.opcode == OP_WRITE) m_backing[off] = rq.write_data;
			for (int i = 0; i < CACHE_ENTRIES; i++) if (m_valid[i]) m_rank[i]++;
			m_valid[slot] = 1;
			m_tag[slot] = phys;
			m_word[slot] = m_backing[off];
			m_rank[slot] = 0;
			r.status = ST_MISS;
		end
		r.physical_address = phys;
		r.data_word = m_word[slot];
		r.address_hits = m_hitc[off];
		r.address_misses = m_missc[off];
		r.total_hits = m_hits_total;
		r.total_misses = m_misses_total;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.payload <= '0;
		end else if (!req_if.valid || req_if.ready) begin
			if (req_if.valid) expected_rsps.push_back(predict_access(req_if.payload));
			if (pending_reqs.size() > 0 && !hold_sender
					&& $urandom_range(99) >= send_idle_pct) begin
				req_if.valid <= 1'b1;
				req_if.payload <= pending_reqs.pop_front();
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_rsps.size() == 0) begin
					report("result with nothing expected");
				end else begin
					rsp_t e, g;
					e = expected_rsps.pop_front();
					g = rsp_if.payload;
					if (g.status !== e.status) report($sformatf("status %0d/%0d", g.status, e.status));
					if (g.physical_address !== e.physical_address)
						report($sformatf("phys %0h/%0h", g.physical_address, e.physical_address));
					if (g.data_word !== e.data_word)
						report($sformatf("data %0h/%0h", g.data_word, e.data_word));
					if (g.evicted !== e.evicted) report("evicted flag");
					if (g.evicted_address !== e.evicted_address)
						report($sformatf("evicted addr %0h/%0h", g.evicted_address, e.evicted_address));
					if (g.address_hits !== e.address_hits) report("address hits");
					if (g.address_misses !== e.address_misses) report("address misses");
					if (g.total_hits !== e.total_hits) report("total hits");
					if (g.total_misses !== e.total_misses) report("total misses");
				end
			end
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.payload <= '{index: idx, data: val};
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		case (idx)
			CFG_CAPACITY: m_capacity = val[3:0];
			CFG_VIRTUAL_BASE: m_vbase = val;
			CFG_PHYSICAL_BASE: m_pbase = val[7:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic req_t make_req(input logic op, input logic [15:0] va,
			input logic [31:0] wd);
		req_t q;
		q.opcode = op;
		q.virtual_address = va;
		q.write_data = wd;
		return q;
	endfunction

	task automatic random_items(input int n);
		int k;
		logic [15:0] va;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 85) va = 16'(m_vbase + $urandom_range(PAGE_COUNT - 1));
			else if (k < 92) va = 16'(m_vbase + PAGE_COUNT + $urandom_range(3));
			else va = 16'($urandom);
			pending_reqs.push_back(make_req(1'($urandom_range(1)), va, $urandom));
		end
	endtask

	initial begin
		int caps [6] = '{4, 1, 8, 0, 15, 3};
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		m_capacity = 4;
		m_vbase = 100;
		m_pbase = 10;
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			m_valid[i] = 0;
			m_rank[i] = 0;
			m_tag[i] = '0;
			m_word[i] = '0;
		end
		for (int i = 0; i < PAGE_COUNT; i++) begin
			m_backing[i] = i;
			m_hitc[i] = 0;
			m_missc[i] = 0;
		end
		m_hits_total = 0;
		m_misses_total = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fills, hits, writes, eviction, faults
		for (int i = 0; i < PAGE_COUNT; i++)
			pending_reqs.push_back(make_req(0, 16'(100 + i), 0));
		pending_reqs.push_back(make_req(1, 16'd107, 32'hFFFFFFFF));
		pending_reqs.push_back(make_req(0, 16'd107, 0));
		pending_reqs.push_back(make_req(1, 16'd100, 32'h00000000));
		pending_reqs.push_back(make_req(0, 16'd100, 0));
		pending_reqs.push_back(make_req(0, 16'd99, 0));
		pending_reqs.push_back(make_req(0, 16'd108, 0));
		pending_reqs.push_back(make_req(1, 16'hFFFF, 32'hA5A5A5A5));
		pending_reqs.push_back(make_req(0, 16'h0000, 0));
		drain();
		write_reg(CFG_CAPACITY, 16'd2);
		write_reg(CFG_PHYSICAL_BASE, 16'd252);
		write_reg(CFG_VIRTUAL_BASE, 16'hFFF8);
		for (int i = 0; i < PAGE_COUNT; i++)
			pending_reqs.push_back(make_req(i[0], 16'(16'hFFF8 + i), $urandom));
		drain();
		write_reg(CFG_VIRTUAL_BASE, 16'd0);
		write_reg(CFG_PHYSICAL_BASE, 16'd0);
		pending_reqs.push_back(make_req(0, 16'd0, 0));
		pending_reqs.push_back(make_req(0, 16'd8, 0));
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 51; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 51; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			write_reg(CFG_CAPACITY, 16'(caps[ph % 6]));
			write_reg(CFG_VIRTUAL_BASE, (ph == 5) ? 16'hFFFF : 16'($urandom));
			write_reg(CFG_PHYSICAL_BASE, (ph % 3 == 0) ? 16'd255 : 16'($urandom_range(255)));
			random_items(40);
			hold_sender = 1'b1;
			while (req_if.valid || expected_rsps.size() > 0) @(posedge clk);
			hold_sender = 1'b0;
			random_items(45);
			drain();
		end

		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
